// ----- hdl/pic_pkg.sv -----
`timescale 1ns / 1ps

package pic_pkg;

  typedef enum logic [2:0] {
    CFG_CENTER_X       = 3'd0,
    CFG_CENTER_Y       = 3'd1,
    CFG_CENTER_Z       = 3'd2,
    CFG_NORMAL_X       = 3'd3,
    CFG_NORMAL_Y       = 3'd4,
    CFG_NORMAL_Z       = 3'd5,
    CFG_DISK_RADIUS    = 3'd6,
    CFG_DISK_THICKNESS = 3'd7
  } cfg_reg_e;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned MID_DEPTH   = 4;
  localparam int unsigned RES_DEPTH   = 16;

endpackage

// ----- hdl/pic_fifo.sv -----
`timescale 1ns / 1ps

module pic_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic [CNT_W-1:0] count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = CNT_W'(cnt_q + 1'b1);
      2'b01:   cnt_d = CNT_W'(cnt_q - 1'b1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/pic_front.sv -----
`timescale 1ns / 1ps

module pic_front
  import pic_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  localparam int unsigned DW = COORD_WIDTH + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic signed [COORD_WIDTH-1:0] center_x_i,
  input  logic signed [COORD_WIDTH-1:0] center_y_i,
  input  logic signed [COORD_WIDTH-1:0] center_z_i,
  input  logic                          mid_pop_i,
  output logic                          mid_empty_o,
  output logic [3*DW-1:0]               mid_data_o
);

  logic signed [DW-1:0] dx, dy, dz;
  logic [3*DW-1:0]      d_packed;

  // The offset from the disk center is exact at one extra bit.
  assign dx = DW'(point_x_i) - DW'(center_x_i);
  assign dy = DW'(point_y_i) - DW'(center_y_i);
  assign dz = DW'(point_z_i) - DW'(center_z_i);
  assign d_packed = {dz, dy, dx};

  pic_fifo #(
    .WIDTH(3 * DW),
    .DEPTH(MID_DEPTH)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (d_packed),
    .full_o (full_o),
    .pop_i  (mid_pop_i),
    .data_o (mid_data_o),
    .empty_o(mid_empty_o),
    .count_o()
  );

endmodule

// ----- hdl/pic_back.sv -----
`timescale 1ns / 1ps

module pic_back
  import pic_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned DW = COORD_WIDTH + 1,
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [COORD_WIDTH-1:0] normal_x_i,
  input  logic signed [COORD_WIDTH-1:0] normal_y_i,
  input  logic signed [COORD_WIDTH-1:0] normal_z_i,
  input  logic [COORD_WIDTH-2:0]        disk_radius_i,
  input  logic [COORD_WIDTH-2:0]        disk_thickness_i,
  input  logic                          mid_empty_i,
  input  logic [3*DW-1:0]               mid_data_i,
  output logic                          mid_pop_o,
  input  logic [RES_CNT_W-1:0]          res_count_i,
  output logic                          res_push_o,
  output logic                          res_inside_o
);

  localparam int unsigned W      = COORD_WIDTH;
  localparam int unsigned F      = FRAC_BITS;
  localparam int unsigned PW     = 2 * W + 1;
  localparam int unsigned NQW    = 2 * W - 1;
  localparam int unsigned NNW    = 2 * W;
  localparam int unsigned DOTW   = 2 * W + 2;
  localparam int unsigned CXW    = 2 * W + 2;
  localparam int unsigned MW     = 2 * W + 1;
  localparam int unsigned H      = W + 1;
  localparam int unsigned HHW    = 2 * W;
  localparam int unsigned HLW    = 2 * W + 1;
  localparam int unsigned LLW    = 2 * W + 2;
  localparam int unsigned TPW    = 2 * W - 1;
  localparam int unsigned TNW    = 3 * W - 1;
  localparam int unsigned RRW    = 2 * W - 2;
  localparam int unsigned SQW    = 4 * W + 2;
  localparam int unsigned XW     = 4 * W + 4;
  localparam int unsigned LIMW   = RRW + 2 * F;
  localparam int unsigned CMPW   = (XW > LIMW) ? XW : LIMW;
  localparam int unsigned GA     = (DOTW + F + 2 > TNW + 2) ? DOTW + F + 2 : TNW + 2;
  localparam int unsigned GW     = (GA > W + 2 * F + 1) ? GA : W + 2 * F + 1;
  localparam int unsigned STAGES = 7;
  localparam int unsigned INF_W  = $clog2(STAGES + 1);
  localparam int unsigned SUM_W  = ((RES_CNT_W > INF_W) ? RES_CNT_W : INF_W) + 1;

  logic                 issue;
  logic [STAGES-1:0]    vld_q, vld_d;
  logic [INF_W-1:0]     infl_q, infl_d;

  logic signed [W-1:0]    n [3];
  logic signed [DW-1:0]   d_q [3];
  logic signed [2*W-1:0]  nsq [3];
  logic signed [PW-1:0]   pr_d [3][3];
  logic signed [PW-1:0]   pr_q [3][3];
  logic [NQW-1:0]         nq_d [3];
  logic [NQW-1:0]         nq_q [3];
  logic signed [DOTW-1:0] dot3_d, dot3_q, dot4_q, dot5_q, dot6_q;
  logic [NNW-1:0]         nn3_d, nn3_q, nn4_q;
  logic signed [CXW-1:0]  cx_d [3];
  logic signed [CXW-1:0]  cx_q [3];
  logic [MW-1:0]          mag_d [3];
  logic [MW-1:0]          mag_q [3];
  logic [HHW-1:0]         hh_d [3];
  logic [HHW-1:0]         hh_q [3];
  logic [HLW-1:0]         hl_d [3];
  logic [HLW-1:0]         hl_q [3];
  logic [LLW-1:0]         ll_d [3];
  logic [LLW-1:0]         ll_q [3];
  logic [TPW-1:0]         tnh_d, tnh_q, tnl_d, tnl_q;
  logic [RRW-1:0]         rr5_d, rr5_q, rr6_q, rr7_q;
  logic [SQW-1:0]         sq_d [3];
  logic [SQW-1:0]         sq_q [3];
  logic [TNW-1:0]         tnn_d, tnn_q;
  logic [XW-1:0]          x2_d, x2_q;
  logic signed [GW-1:0]   dot_ext, tnn_ext, g_d, g_q;
  logic [GW-1:0]          top;
  logic [CMPW-1:0]        lim;
  logic                   out_height, out_radial;

  assign n[0] = normal_x_i;
  assign n[1] = normal_y_i;
  assign n[2] = normal_z_i;

  // A point is issued only when the result queue has room for everything in flight.
  assign issue = ~mid_empty_i &
                 ((SUM_W'(res_count_i) + SUM_W'(infl_q)) < SUM_W'(RES_DEPTH));
  assign mid_pop_o = issue;
  assign vld_d = {vld_q[STAGES-2:0], issue};

  always_comb begin
    unique case ({issue, vld_q[STAGES-1]})
      2'b10:   infl_d = INF_W'(infl_q + 1'b1);
      2'b01:   infl_d = INF_W'(infl_q - 1'b1);
      default: infl_d = infl_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      infl_q <= '0;
    end else begin
      vld_q  <= vld_d;
      infl_q <= infl_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nsq[i]  = (2 * W)'(n[i]) * (2 * W)'(n[i]);
      nq_d[i] = nsq[i][NQW-1:0];
      for (int j = 0; j < 3; j++) begin
        pr_d[i][j] = PW'(n[i]) * PW'(d_q[j]);
      end
    end
  end

  always_comb begin
    dot3_d = DOTW'(pr_q[0][0]) + DOTW'(pr_q[1][1]) + DOTW'(pr_q[2][2]);
    nn3_d  = NNW'(nq_q[0]) + NNW'(nq_q[1]) + NNW'(nq_q[2]);
    cx_d[0] = CXW'(pr_q[1][2]) - CXW'(pr_q[2][1]);
    cx_d[1] = CXW'(pr_q[2][0]) - CXW'(pr_q[0][2]);
    cx_d[2] = CXW'(pr_q[0][1]) - CXW'(pr_q[1][0]);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = cx_q[i][CXW-1] ? MW'(-cx_q[i]) : MW'(cx_q[i]);
    end
  end

  // Each square is split into three partial products of half width.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hh_d[i] = HHW'(mag_q[i][MW-1:H]) * HHW'(mag_q[i][MW-1:H]);
      hl_d[i] = HLW'(mag_q[i][MW-1:H]) * HLW'(mag_q[i][H-1:0]);
      ll_d[i] = LLW'(mag_q[i][H-1:0]) * LLW'(mag_q[i][H-1:0]);
    end
    tnh_d = TPW'(disk_thickness_i) * TPW'(nn4_q[NNW-1:W]);
    tnl_d = TPW'(disk_thickness_i) * TPW'(nn4_q[W-1:0]);
    rr5_d = RRW'(disk_radius_i) * RRW'(disk_radius_i);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = (SQW'(hh_q[i]) << (2 * H)) + (SQW'(hl_q[i]) << (H + 1)) + SQW'(ll_q[i]);
    end
    tnn_d = (TNW'(tnh_q) << W) + TNW'(tnl_q);
  end

  always_comb begin
    x2_d    = XW'(sq_q[0]) + XW'(sq_q[1]) + XW'(sq_q[2]);
    dot_ext = GW'(dot6_q);
    tnn_ext = $signed(GW'(tnn_q));
    g_d     = (dot_ext <<< (F + 1)) + tnn_ext;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d_q[i]   <= mid_data_i[i*DW +: DW];
      nq_q[i]  <= nq_d[i];
      cx_q[i]  <= cx_d[i];
      mag_q[i] <= mag_d[i];
      hh_q[i]  <= hh_d[i];
      hl_q[i]  <= hl_d[i];
      ll_q[i]  <= ll_d[i];
      sq_q[i]  <= sq_d[i];
      for (int j = 0; j < 3; j++) begin
        pr_q[i][j] <= pr_d[i][j];
      end
    end
    dot3_q <= dot3_d;
    dot4_q <= dot3_q;
    dot5_q <= dot4_q;
    dot6_q <= dot5_q;
    nn3_q  <= nn3_d;
    nn4_q  <= nn3_q;
    tnh_q  <= tnh_d;
    tnl_q  <= tnl_d;
    rr5_q  <= rr5_d;
    rr6_q  <= rr5_q;
    rr7_q  <= rr6_q;
    tnn_q  <= tnn_d;
    x2_q   <= x2_d;
    g_q    <= g_d;
  end

  assign top = GW'(disk_thickness_i) << (2 * F + 1);
  assign lim = CMPW'(rr7_q) << (2 * F);
  assign out_height = g_q[GW-1] || ($unsigned(g_q) > top);
  assign out_radial = CMPW'(x2_q) > lim;

  // A zero thickness reports every point as inside.
  assign res_push_o   = vld_q[STAGES-1];
  assign res_inside_o = (disk_thickness_i == '0) || !(out_height || out_radial);

endmodule

// ----- hdl/point_in_cylinder_test_core.sv -----
`timescale 1ns / 1ps
// Throughput: one point per cycle, sustained while the consumer keeps popping.
// The point queue and the 7-stage multiply pipeline set the latency;
// a 16-entry result queue bounds what is in flight.
// Reset empties both queues and loads a unit disk at the origin with normal +z.

module point_in_cylinder_test_core
  import pic_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          is_inside_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0]        cfg_index_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  logic signed [COORD_WIDTH-1:0] center_x_q, center_y_q, center_z_q;
  logic signed [COORD_WIDTH-1:0] normal_x_q, normal_y_q, normal_z_q;
  logic [COORD_WIDTH-2:0]        disk_radius_q, disk_thickness_q;

  logic                 mid_pop, mid_empty;
  logic [3*DW-1:0]      mid_data;
  logic [RES_CNT_W-1:0] res_count;
  logic                 res_push, res_inside;
  logic [0:0]           res_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q       <= '0;
      center_y_q       <= '0;
      center_z_q       <= '0;
      normal_x_q       <= '0;
      normal_y_q       <= '0;
      normal_z_q       <= COORD_WIDTH'(1) << FRAC_BITS;
      disk_radius_q    <= (COORD_WIDTH - 1)'(1) << FRAC_BITS;
      disk_thickness_q <= (COORD_WIDTH - 1)'(1) << FRAC_BITS;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_CENTER_X:       center_x_q       <= cfg_data_i;
        CFG_CENTER_Y:       center_y_q       <= cfg_data_i;
        CFG_CENTER_Z:       center_z_q       <= cfg_data_i;
        CFG_NORMAL_X:       normal_x_q       <= cfg_data_i;
        CFG_NORMAL_Y:       normal_y_q       <= cfg_data_i;
        CFG_NORMAL_Z:       normal_z_q       <= cfg_data_i;
        CFG_DISK_RADIUS:    disk_radius_q    <= cfg_data_i[COORD_WIDTH-2:0];
        CFG_DISK_THICKNESS: disk_thickness_q <= cfg_data_i[COORD_WIDTH-2:0];
      endcase
    end
  end

  pic_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .point_z_i  (point_z_i),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .center_z_i (center_z_q),
    .mid_pop_i  (mid_pop),
    .mid_empty_o(mid_empty),
    .mid_data_o (mid_data)
  );

  pic_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .normal_x_i      (normal_x_q),
    .normal_y_i      (normal_y_q),
    .normal_z_i      (normal_z_q),
    .disk_radius_i   (disk_radius_q),
    .disk_thickness_i(disk_thickness_q),
    .mid_empty_i     (mid_empty),
    .mid_data_i      (mid_data),
    .mid_pop_o       (mid_pop),
    .res_count_i     (res_count),
    .res_push_o      (res_push),
    .res_inside_o    (res_inside)
  );

  pic_fifo #(
    .WIDTH(1),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_inside),
    .full_o (),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty),
    .count_o(res_count)
  );

  assign is_inside_o = res_out[0];

endmodule
